// File: hdl/iss_pkg.sv
// Shared types and constants for the indexed sequence store.
// Holds field widths, operation codes, sequencer states and the result record.
// No dependencies; every other file of the block but iss_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package iss_pkg;

  // Default sizes of the store.
  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned ITEM_WIDTH_DEF = 32;

  // Fixed widths of the channel fields.
  localparam int unsigned KIND_W = 3;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned LEN_W  = 7;

  // Index reported when nothing was acted on (minus one).
  localparam logic [IDX_W-1:0] INDEX_NONE = '1;

  // Operation codes carried in the kind field.
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT_AT  = 3'd0,
    KIND_SORTED     = 3'd1,
    KIND_ERASE      = 3'd2,
    KIND_REMOVE_ALL = 3'd3,
    KIND_READ       = 3'd4,
    KIND_WRITE      = 3'd5,
    KIND_FIND       = 3'd6
  } iss_kind_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_SHIFT_UP,
    ST_SHIFT_DN,
    ST_COMPACT,
    ST_RDWAIT,
    ST_PUT,
    ST_DONE
  } iss_state_e;

  // Result record handed from the sequencer to the output register.
  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] index;
    logic [LEN_W-1:0] removed_count;
    logic [VAL_W-1:0] read_value;
    logic [LEN_W-1:0] length;
  } iss_result_t;

endpackage

`default_nettype wire

// File: hdl/iss_if.sv
// Request and response channel interfaces of the indexed sequence store.
// Each carries valid, ready and the payload; widths come from iss_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface iss_req_if import iss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [POS_W-1:0]  position;
  logic [VAL_W-1:0]  item_value;

  modport source (output valid, kind, position, item_value, input ready);
  modport sink   (input valid, kind, position, item_value, output ready);
endinterface

interface iss_rsp_if import iss_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             ok;
  logic [IDX_W-1:0] index;
  logic [LEN_W-1:0] removed_count;
  logic [VAL_W-1:0] read_value;
  logic [LEN_W-1:0] length;

  modport source (output valid, ok, index, removed_count, read_value, length,
                  input ready);
  modport sink   (input valid, ok, index, removed_count, read_value, length,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/iss_ram.sv
// Item memory of the indexed sequence store: one write and one read port.
// Read data is registered; contents have no reset. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module iss_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/iss_ctrl.sv
// Sequencer of the indexed sequence store: decodes a transaction and walks the
// memory one entry per cycle through a shared compare unit. Uses iss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iss_ctrl import iss_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned ITEM_WIDTH = ITEM_WIDTH_DEF,
  localparam int unsigned AW        = $clog2(CAPACITY)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic [POS_W-1:0]      pos_i,
  input  logic [VAL_W-1:0]      val_i,
  output logic                  ready_o,
  input  logic                  slot_free_i,
  output logic                  done_o,
  output iss_result_t           res_o,
  output logic                  mem_we_o,
  output logic [AW-1:0]         mem_waddr_o,
  output logic [ITEM_WIDTH-1:0] mem_wdata_o,
  output logic                  mem_re_o,
  output logic [AW-1:0]         mem_raddr_o,
  input  logic [ITEM_WIDTH-1:0] mem_rdata_i
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] FULL = CW'(CAPACITY);

  iss_state_e            state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  iss_kind_e             kind_q;
  logic [POS_W-1:0]      pos_q;
  logic [ITEM_WIDTH-1:0] val_q;
  logic [CW-1:0]         tag_q, tag_d;
  logic [CW-1:0]         tgt_q, tgt_d;
  logic [CW-1:0]         wr_q, wr_d;
  logic                  ok_q, ok_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [CW-1:0]         rem_q, rem_d;
  logic [VAL_W-1:0]      rdv_q, rdv_d;

  // Shared compare unit on the memory read data.
  logic eq, le, hit;
  assign eq  = (mem_rdata_i == val_q);
  assign le  = (val_q <= mem_rdata_i);
  assign hit = (kind_q == KIND_SORTED) ? le : eq;

  // Range checks and loop bounds.
  logic [CW-1:0] cnt_m1, pos_c;
  logic          pos_le_cnt, pos_lt_cnt, pos_eq_cnt, pos_last, full, empty, last;
  logic          dec_ok;
  assign cnt_m1     = cnt_q - ONE;
  assign pos_c      = CW'(pos_q);
  assign pos_le_cnt = LW'(pos_q) <= LW'(cnt_q);
  assign pos_lt_cnt = LW'(pos_q) < LW'(cnt_q);
  assign pos_eq_cnt = LW'(pos_q) == LW'(cnt_q);
  assign pos_last   = pos_lt_cnt && (pos_c == cnt_m1);
  assign full       = (cnt_q == FULL);
  assign empty      = (cnt_q == '0);
  assign last       = (tag_q == cnt_m1);

  // Whether the decoded transaction passes its checks.
  always_comb begin
    case (kind_q)
      KIND_INSERT_AT:  dec_ok = pos_le_cnt && !full;
      KIND_SORTED:     dec_ok = !full;
      KIND_ERASE:      dec_ok = pos_lt_cnt;
      KIND_REMOVE_ALL: dec_ok = 1'b1;
      KIND_READ:       dec_ok = pos_lt_cnt;
      KIND_WRITE:      dec_ok = pos_lt_cnt;
      KIND_FIND:       dec_ok = !empty;
      default:         dec_ok = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (!dec_ok) begin
          state_d = ST_DONE;
        end else begin
          case (kind_q)
            KIND_INSERT_AT:  state_d = pos_eq_cnt ? ST_PUT : ST_SHIFT_UP;
            KIND_SORTED:     state_d = empty ? ST_PUT : ST_SCAN;
            KIND_ERASE:      state_d = pos_last ? ST_DONE : ST_SHIFT_DN;
            KIND_REMOVE_ALL: state_d = empty ? ST_DONE : ST_COMPACT;
            KIND_READ:       state_d = ST_RDWAIT;
            KIND_FIND:       state_d = ST_SCAN;
            default:         state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_d = (kind_q == KIND_SORTED) ? ST_SHIFT_UP : ST_DONE;
        end else if (last) begin
          state_d = (kind_q == KIND_SORTED) ? ST_PUT : ST_DONE;
        end
      end
      ST_SHIFT_UP: begin
        if (tag_q == tgt_q) state_d = ST_PUT;
      end
      ST_SHIFT_DN: begin
        if (last) state_d = ST_DONE;
      end
      ST_COMPACT: begin
        if (last) state_d = ST_DONE;
      end
      ST_RDWAIT: state_d = ST_DONE;
      ST_PUT:    state_d = ST_DONE;
      ST_DONE: begin
        if (slot_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    ready_o = (state_q == ST_IDLE);
    done_o  = (state_q == ST_DONE) && slot_free_i;
  end

  // Datapath: pointers, memory accesses and result fields.
  always_comb begin
    cnt_d       = cnt_q;
    tag_d       = tag_q;
    tgt_d       = tgt_q;
    wr_d        = wr_q;
    ok_d        = ok_q;
    idx_d       = idx_q;
    rem_d       = rem_q;
    rdv_d       = rdv_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = tag_q[AW-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = tag_q[AW-1:0];
    case (state_q)
      ST_DECODE: begin
        ok_d  = 1'b0;
        idx_d = INDEX_NONE;
        rem_d = '0;
        rdv_d = '0;
        if (dec_ok) begin
          case (kind_q)
            KIND_INSERT_AT: begin
              tgt_d = pos_c;
              if (!pos_eq_cnt) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = cnt_m1[AW-1:0];
                tag_d       = cnt_m1;
              end
            end
            KIND_SORTED: begin
              tgt_d       = '0;
              mem_re_o    = !empty;
              mem_raddr_o = '0;
              tag_d       = '0;
            end
            KIND_ERASE: begin
              ok_d  = 1'b1;
              idx_d = IDX_W'(pos_q);
              if (pos_last) begin
                cnt_d = cnt_m1;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = pos_c[AW-1:0] + AW'(1);
                tag_d       = pos_c + ONE;
              end
            end
            KIND_REMOVE_ALL: begin
              ok_d        = 1'b1;
              mem_re_o    = !empty;
              mem_raddr_o = '0;
              tag_d       = '0;
              wr_d        = '0;
            end
            KIND_READ: begin
              ok_d        = 1'b1;
              idx_d       = IDX_W'(pos_q);
              mem_re_o    = 1'b1;
              mem_raddr_o = pos_c[AW-1:0];
            end
            KIND_WRITE: begin
              ok_d        = 1'b1;
              idx_d       = IDX_W'(pos_q);
              mem_we_o    = 1'b1;
              mem_waddr_o = pos_c[AW-1:0];
              mem_wdata_o = val_q;
            end
            KIND_FIND: begin
              mem_re_o    = 1'b1;
              mem_raddr_o = '0;
              tag_d       = '0;
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end
      // Look for the first entry that is not smaller, or that is equal.
      ST_SCAN: begin
        if (hit) begin
          if (kind_q == KIND_SORTED) begin
            tgt_d       = tag_q;
            mem_re_o    = 1'b1;
            mem_raddr_o = cnt_m1[AW-1:0];
            tag_d       = cnt_m1;
          end else begin
            ok_d  = 1'b1;
            idx_d = IDX_W'(tag_q);
          end
        end else if (last) begin
          tgt_d = cnt_q;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = tag_q[AW-1:0] + AW'(1);
          tag_d       = tag_q + ONE;
        end
      end
      // Move entries up by one, from the top down to the target.
      ST_SHIFT_UP: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = tag_q[AW-1:0] + AW'(1);
        if (tag_q != tgt_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = tag_q[AW-1:0] - AW'(1);
          tag_d       = tag_q - ONE;
        end
      end
      // Move entries down by one, from above the erased slot to the top.
      ST_SHIFT_DN: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = tag_q[AW-1:0] - AW'(1);
        if (last) begin
          cnt_d = cnt_m1;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = tag_q[AW-1:0] + AW'(1);
          tag_d       = tag_q + ONE;
        end
      end
      // Copy down every entry that differs from the value; count the others.
      ST_COMPACT: begin
        mem_waddr_o = wr_q[AW-1:0];
        if (eq) begin
          rem_d = rem_q + ONE;
        end else begin
          mem_we_o = 1'b1;
          wr_d     = wr_q + ONE;
        end
        if (last) begin
          cnt_d = eq ? wr_q : wr_q + ONE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = tag_q[AW-1:0] + AW'(1);
          tag_d       = tag_q + ONE;
        end
      end
      ST_RDWAIT: begin
        rdv_d = VAL_W'(mem_rdata_i);
      end
      ST_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = tgt_q[AW-1:0];
        mem_wdata_o = val_q;
        cnt_d       = cnt_q + ONE;
        ok_d        = 1'b1;
        idx_d       = IDX_W'(tgt_q);
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Transaction fields and working registers.
  always_ff @(posedge clk_i) begin
    if (start_i && ready_o) begin
      kind_q <= iss_kind_e'(kind_i);
      pos_q  <= pos_i;
      val_q  <= ITEM_WIDTH'(val_i);
    end
    tag_q <= tag_d;
    tgt_q <= tgt_d;
    wr_q  <= wr_d;
    ok_q  <= ok_d;
    idx_q <= idx_d;
    rem_q <= rem_d;
    rdv_q <= rdv_d;
  end

  // Result record.
  assign res_o.ok            = ok_q;
  assign res_o.index         = idx_q;
  assign res_o.removed_count = LEN_W'(rem_q);
  assign res_o.read_value    = rdv_q;
  assign res_o.length        = LEN_W'(cnt_q);

endmodule

`default_nettype wire

// File: hdl/indexed_sequence_store_core.sv
// Indexed sequence store: a bounded ordered list of items held in a memory.
// Request channel req_i carries kind, position and item_value; response
// channel rsp_o returns ok, index, removed_count, read_value and length.
// A request transaction is taken only while the sequencer is idle. It is
// decoded first; operations that move or search entries then walk the memory
// one entry per cycle through the single read port and the shared comparator.
// The next request is taken the cycle after the result enters the output
// register. The output register holds a result until the receiver takes it;
// while it is stalled a finished operation waits and no new request is taken.
// Reset clears the item count to zero; memory contents are left as they are
// and need no clearing pass, since only positions below the count are read.
`timescale 1ns / 1ps
`default_nettype none

module indexed_sequence_store_core import iss_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned ITEM_WIDTH = ITEM_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  iss_req_if.sink   req_i,
  iss_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic                  ctrl_ready;
  logic                  slot_free;
  logic                  done;
  iss_result_t           res;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [ITEM_WIDTH-1:0] mem_wdata, mem_rdata;
  logic                  out_valid_q;
  iss_result_t           out_q;

  assign req_i.ready = ctrl_ready;

  iss_ctrl #(
    .CAPACITY   (CAPACITY),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (req_i.valid),
    .kind_i      (req_i.kind),
    .pos_i       (req_i.position),
    .val_i       (req_i.item_value),
    .ready_o     (ctrl_ready),
    .slot_free_i (slot_free),
    .done_o      (done),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  iss_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ITEM_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: free when empty or being taken this cycle.
  assign slot_free = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.ok            = out_q.ok;
  assign rsp_o.index         = out_q.index;
  assign rsp_o.removed_count = out_q.removed_count;
  assign rsp_o.read_value    = out_q.read_value;
  assign rsp_o.length        = out_q.length;

  // A taken request keeps the sequencer busy for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while a transaction was in progress");

  // A rejected result reports no position, no removals and no data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ok |-> rsp_o.index == INDEX_NONE &&
      rsp_o.removed_count == '0 && rsp_o.read_value == '0)
    else $error("rejected result carries data");

  // A new result is only loaded when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && out_valid_q |-> rsp_o.ready)
    else $error("result overwrote a pending transaction");

endmodule

`default_nettype wire

// File: bench/iss_result_checker.sv
// Response checker for the indexed sequence store core.
// Watches both channel interfaces, keeps a shadow copy of the store, and compares each response.
// Depends on iss_pkg and the channel interfaces in iss_if.sv.
`timescale 1ns / 1ps

module iss_result_checker import iss_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned ITEM_WIDTH = ITEM_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  iss_req_if   req_mon,
  iss_rsp_if   rsp_mon,
  output int   errors_o,
  output int   pending_o,
  output int   level_o,
  output int   checked_o,
  output int   rejected_o,
  output int   peak_o
);

  localparam int unsigned REPORT_LIMIT = 20;
  localparam logic [VAL_W-1:0] ITEM_MASK = VAL_W'((64'd1 << ITEM_WIDTH) - 64'd1);

  // Shadow copy of the store contents and its fill count.
  logic [VAL_W-1:0] shadow_mem [CAPACITY];
  int unsigned      shadow_len;

  // Responses still owed by the block, oldest first.
  iss_result_t      owed_rsp_q [$];
  iss_result_t      want;
  int               mismatches;
  int               checked;
  int               rejected;
  int               peak;

  // Applies one request to the shadow store and returns the response it should produce.
  function automatic iss_result_t apply_request(input logic [KIND_W-1:0] kind,
                                                input logic [POS_W-1:0]  pos,
                                                input logic [VAL_W-1:0]  val);
    iss_result_t      res;
    logic [VAL_W-1:0] v;
    int unsigned      slot;
    int unsigned      keep;
    int unsigned      hits;
    res       = '0;
    res.index = INDEX_NONE;
    v         = val & ITEM_MASK;
    slot      = 0;
    keep      = 0;
    hits      = 0;
    case (kind)
      KIND_INSERT_AT: begin
        if (pos <= shadow_len && shadow_len < CAPACITY) begin
          for (int unsigned i = shadow_len; i > pos; i--) shadow_mem[i] = shadow_mem[i-1];
          shadow_mem[pos] = v;
          shadow_len++;
          res.ok    = 1'b1;
          res.index = IDX_W'(pos);
        end
      end
      KIND_SORTED: begin
        if (shadow_len < CAPACITY) begin
          // The new item goes in front of the first entry that is not smaller.
          while (slot < shadow_len && v > shadow_mem[slot]) slot++;
          for (int unsigned i = shadow_len; i > slot; i--) shadow_mem[i] = shadow_mem[i-1];
          shadow_mem[slot] = v;
          shadow_len++;
          res.ok    = 1'b1;
          res.index = IDX_W'(slot);
        end
      end
      KIND_ERASE: begin
        if (pos < shadow_len) begin
          for (int unsigned i = pos; i + 1 < shadow_len; i++) shadow_mem[i] = shadow_mem[i+1];
          shadow_len--;
          res.ok    = 1'b1;
          res.index = IDX_W'(pos);
        end
      end
      KIND_REMOVE_ALL: begin
        // Compact the surviving entries toward the front.
        for (int unsigned i = 0; i < shadow_len; i++) begin
          if (shadow_mem[i] == v) begin
            hits++;
          end else begin
            shadow_mem[keep] = shadow_mem[i];
            keep++;
          end
        end
        shadow_len        = keep;
        res.ok            = 1'b1;
        res.removed_count = LEN_W'(hits);
      end
      KIND_READ: begin
        if (pos < shadow_len) begin
          res.ok         = 1'b1;
          res.index      = IDX_W'(pos);
          res.read_value = shadow_mem[pos];
        end
      end
      KIND_WRITE: begin
        if (pos < shadow_len) begin
          shadow_mem[pos] = v;
          res.ok          = 1'b1;
          res.index       = IDX_W'(pos);
        end
      end
      KIND_FIND: begin
        while (slot < shadow_len && shadow_mem[slot] != v) slot++;
        if (slot < shadow_len) begin
          res.ok    = 1'b1;
          res.index = IDX_W'(slot);
        end
      end
      default: begin
        // Unused kind: rejected, nothing changes.
      end
    endcase
    res.length = LEN_W'(shadow_len);
    return res;
  endfunction

  // Prints one line per mismatch, up to a limit, and counts every one.
  task automatic report_mismatch(input string what);
    if (mismatches < REPORT_LIMIT) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  // Check each response transaction, then predict from each request transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_len = 0;
      owed_rsp_q.delete();
      mismatches = 0;
      checked    = 0;
      rejected   = 0;
      peak       = 0;
      errors_o   <= 0;
      pending_o  <= 0;
      level_o    <= 0;
      checked_o  <= 0;
      rejected_o <= 0;
      peak_o     <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (owed_rsp_q.size() == 0) begin
          report_mismatch("response transaction with no request outstanding");
        end else begin
          want = owed_rsp_q.pop_front();
          if (rsp_mon.ok !== want.ok)
            report_mismatch($sformatf("ok got %0b, expected %0b", rsp_mon.ok, want.ok));
          if (rsp_mon.index !== want.index)
            report_mismatch($sformatf("index got %0d, expected %0d",
                                      $signed(rsp_mon.index), $signed(want.index)));
          if (rsp_mon.removed_count !== want.removed_count)
            report_mismatch($sformatf("removed_count got %0d, expected %0d",
                                      rsp_mon.removed_count, want.removed_count));
          if (rsp_mon.read_value !== want.read_value)
            report_mismatch($sformatf("read_value got 0x%08h, expected 0x%08h",
                                      rsp_mon.read_value, want.read_value));
          if (rsp_mon.length !== want.length)
            report_mismatch($sformatf("length got %0d, expected %0d",
                                      rsp_mon.length, want.length));
          if (!want.ok) rejected++;
          checked++;
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        owed_rsp_q.push_back(apply_request(req_mon.kind, req_mon.position,
                                           req_mon.item_value));
        if (shadow_len > peak) peak = shadow_len;
      end
      errors_o   <= mismatches;
      pending_o  <= owed_rsp_q.size();
      level_o    <= shadow_len;
      checked_o  <= checked;
      rejected_o <= rejected;
      peak_o     <= peak;
    end
  end

endmodule

// File: bench/tb.sv
// Top of the indexed sequence store regression: clock, reset, stimulus and verdict.
// Instantiates indexed_sequence_store_core beside iss_result_checker.
// Depends on iss_pkg, the channel interfaces and both modules.
`timescale 1ns / 1ps

module tb;
  import iss_pkg::*;

  localparam int unsigned CAPACITY      = CAPACITY_DEF;
  localparam int unsigned PHASE_ITEMS   = 180;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 2 * CAPACITY + 8;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles    = 0;
  bit          growing;
  int          errors;
  int          pending;
  int          level;
  int          checked;
  int          rejected;
  int          peak;

  iss_req_if req ();
  iss_rsp_if rsp ();

  indexed_sequence_store_core #(
    .CAPACITY  (CAPACITY),
    .ITEM_WIDTH(ITEM_WIDTH_DEF)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  iss_result_checker #(
    .CAPACITY  (CAPACITY),
    .ITEM_WIDTH(ITEM_WIDTH_DEF)
  ) u_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_mon   (req),
    .rsp_mon   (rsp),
    .errors_o  (errors),
    .pending_o (pending),
    .level_o   (level),
    .checked_o (checked),
    .rejected_o(rejected),
    .peak_o    (peak)
  );

  // Free-running clock.
  always #1 clk_i = ~clk_i;

  // Guard against a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("indexed_sequence_store_core regression: fail");
      $finish;
    end
  end

  // Response side back-pressure.
  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Drives one request and returns at the edge where the transaction is taken.
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic [POS_W-1:0]  pos,
                              input logic [VAL_W-1:0]  val);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid      <= 1'b1;
    req.kind       <= kind;
    req.position   <= pos;
    req.item_value <= val;
    do @(posedge clk_i); while (!req.ready);
  endtask

  // Holds off new requests until every outstanding response has come back.
  task automatic wait_drained();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Mostly values from a small set so that find and remove-all hit, the rest fully random.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h0000_0100;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h8000_0000;
      5:       return 32'h5A5A_5A5A;
      default: return $urandom();
    endcase
  endfunction

  // Positions mostly land inside the current fill, sometimes anywhere in the field.
  function automatic logic [POS_W-1:0] pick_position(input int unsigned fill);
    int unsigned r;
    r = $urandom_range(19);
    if (r < 2) return POS_W'($urandom_range(127));
    if (r == 2) return POS_W'(fill);
    return POS_W'($urandom_range(fill));
  endfunction

  // Operation mix leans toward inserts while growing and toward removals while shrinking.
  function automatic logic [KIND_W-1:0] pick_kind(input bit grow);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 2) return KIND_UNUSED;
    if (grow) begin
      if (r < 45) return KIND_INSERT_AT;
      if (r < 66) return KIND_SORTED;
      if (r < 72) return KIND_ERASE;
      if (r < 74) return KIND_REMOVE_ALL;
      if (r < 83) return KIND_READ;
      if (r < 91) return KIND_WRITE;
      return KIND_FIND;
    end
    if (r < 12) return KIND_INSERT_AT;
    if (r < 18) return KIND_SORTED;
    if (r < 60) return KIND_ERASE;
    if (r < 68) return KIND_REMOVE_ALL;
    if (r < 78) return KIND_READ;
    if (r < 88) return KIND_WRITE;
    return KIND_FIND;
  endfunction

  // Main stimulus sequence.
  initial begin
    req.valid      <= 1'b0;
    req.kind       <= KIND_INSERT_AT;
    req.position   <= '0;
    req.item_value <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: operations on an empty store, then edge positions and values.
    send_request(KIND_READ,       7'd0,   32'h0);
    send_request(KIND_ERASE,      7'd0,   32'h0);
    send_request(KIND_WRITE,      7'd0,   32'h1);
    send_request(KIND_FIND,       7'd0,   32'h0);
    send_request(KIND_REMOVE_ALL, 7'd0,   32'h0);
    send_request(KIND_UNUSED,     7'd0,   32'hFFFF_FFFF);
    send_request(KIND_INSERT_AT,  7'd1,   32'h1);
    send_request(KIND_INSERT_AT,  7'd0,   32'h0000_0100);
    send_request(KIND_INSERT_AT,  7'd1,   32'hFFFF_FFFF);
    send_request(KIND_SORTED,     7'd0,   32'h8000_0000);
    send_request(KIND_SORTED,     7'd0,   32'h0000_0100);
    send_request(KIND_SORTED,     7'd0,   32'h0);
    send_request(KIND_SORTED,     7'd127, 32'hFFFF_FFFF);
    send_request(KIND_INSERT_AT,  7'd6,   32'h5A5A_5A5A);
    send_request(KIND_INSERT_AT,  7'd127, 32'h1);
    send_request(KIND_READ,       7'd6,   32'h0);
    send_request(KIND_READ,       7'd7,   32'h0);
    send_request(KIND_WRITE,      7'd2,   32'hA5A5_A5A5);
    send_request(KIND_FIND,       7'd0,   32'hFFFF_FFFF);
    send_request(KIND_FIND,       7'd0,   32'h1234_5678);
    send_request(KIND_REMOVE_ALL, 7'd0,   32'hFFFF_FFFF);
    send_request(KIND_ERASE,      7'd0,   32'h0);
    send_request(KIND_ERASE,      7'd3,   32'h0);
    send_request(KIND_ERASE,      7'd64,  32'h0);
    send_request(KIND_READ,       7'd0,   32'h0);
    wait_drained();

    // Fill the store to capacity, then push against the full limit.
    while (level < CAPACITY) begin
      send_request(($urandom_range(1) != 0) ? KIND_INSERT_AT : KIND_SORTED,
                   pick_position(level), pick_value());
    end
    wait_drained();
    send_request(KIND_INSERT_AT, 7'd64, 32'h1);
    send_request(KIND_SORTED,    7'd0,  32'h0);
    send_request(KIND_INSERT_AT, 7'd0,  32'hFFFF_FFFF);
    send_request(KIND_READ,      7'd63, 32'h0);
    send_request(KIND_WRITE,     7'd63, 32'hFFFF_FFFF);
    send_request(KIND_READ,      7'd64, 32'h0);
    wait_drained();

    // Random traffic under four flow-control regimes.
    growing = 1'b0;
    for (int p = 0; p < 4; p++) begin
      case (p)
        1:       begin idle_pct = 80; stall_pct <= 0;  end
        2:       begin idle_pct = 0;  stall_pct <= 80; end
        3:       begin idle_pct = 36; stall_pct <= 36; end
        default: begin idle_pct = 0;  stall_pct <= 0;  end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (growing && level >= CAPACITY && $urandom_range(3) == 0) begin
          growing = 1'b0;
        end else if (!growing && level == 0 && $urandom_range(1) == 0) begin
          growing = 1'b1;
        end
        send_request(pick_kind(growing), pick_position(level), pick_value());
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Checked %0d responses, %0d of them rejections, across directed, fill",
             checked, rejected);
    $display("and four flow-control phases; store depth peaked at %0d of %0d.",
             peak, CAPACITY);
    if (errors == 0 && pending == 0) begin
      $display("indexed_sequence_store_core regression: pass");
    end else begin
      $display("indexed_sequence_store_core regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/iss_pkg.sv
hdl/iss_if.sv
hdl/iss_ram.sv
hdl/iss_ctrl.sv
hdl/indexed_sequence_store_core.sv
bench/iss_result_checker.sv
bench/tb.sv
